// ----- hdl/bfs_pkg.sv -----
`default_nettype none
package bfs_pkg;

  localparam int SRC_MAX_W = 256;
  localparam int SRC_MAX_H = 256;
  localparam int SCREEN_W  = 400;
  localparam int SCREEN_H  = 240;

  localparam int SRC_XW = $clog2(SRC_MAX_W);
  localparam int SRC_YW = $clog2(SRC_MAX_H);
  localparam int ADDR_W = SRC_XW + SRC_YW;
  localparam int DEPTH  = SRC_MAX_W * SRC_MAX_H;

  localparam int COLOR_W = 24;
  localparam int CHAN_W  = 8;
  localparam int NUM_CH  = 3;
  localparam int OFF_W   = 19;

  // divider: numerator up to (2x+1)*sw*256, quotient below sw*256
  localparam int NUM_W = 27;
  localparam int DEN_W = 10;
  localparam int QUO_W = 17;

  localparam int HALF_PIX  = 128;
  localparam int ONE_W     = 256;
  localparam int ROUND_OFS = 32768;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_W  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_H  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_W  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_H  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_L  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_T  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER = 3'd6;

  localparam logic CMD_WRITE   = 1'b0;
  localparam logic CMD_REQUEST = 1'b1;

  typedef struct packed {
    logic               vld;
    logic               cmd;
    logic [8:0]         x;
    logic [7:0]         y;
    logic [COLOR_W-1:0] color;
    logic               ok;
    logic [OFF_W-1:0]   off;
  } side_t;

endpackage
`default_nettype wire

// ----- hdl/bfs_if.sv -----
`default_nettype none
interface bfs_in_if;
  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic [8:0]                  pos_x;
  logic [7:0]                  pos_y;
  logic [bfs_pkg::COLOR_W-1:0] pixel_color;
  modport source (output valid, cmd, pos_x, pos_y, pixel_color, input ready);
  modport sink (input valid, cmd, pos_x, pos_y, pixel_color, output ready);
endinterface

interface bfs_out_if;
  logic                        valid;
  logic                        ready;
  logic [bfs_pkg::COLOR_W-1:0] out_color;
  logic [bfs_pkg::OFF_W-1:0]   byte_offset;
  logic                        valid_res;
  modport source (output valid, out_color, byte_offset, valid_res, input ready);
  modport sink (input valid, out_color, byte_offset, valid_res, output ready);
endinterface
`default_nettype wire

// ----- hdl/bfs_div.sv -----
`default_nettype none
module bfs_div (
  input  wire logic                        clk_i,
  input  wire logic                        en_i,
  input  wire logic [bfs_pkg::NUM_W-1:0]   num_i,
  input  wire logic [bfs_pkg::DEN_W-1:0]   den_i,
  output logic      [bfs_pkg::QUO_W-1:0]   quo_o
);

  logic [bfs_pkg::NUM_W-1:0] rem_q [bfs_pkg::QUO_W];
  logic [bfs_pkg::DEN_W-1:0] den_q [bfs_pkg::QUO_W];
  logic [bfs_pkg::QUO_W-1:0] quo_q [bfs_pkg::QUO_W];

  // one quotient bit per stage, most significant first
  for (genvar k = 0; k < bfs_pkg::QUO_W; k++) begin : g_stage
    localparam int B = bfs_pkg::QUO_W - 1 - k;
    logic [bfs_pkg::NUM_W-1:0] rin;
    logic [bfs_pkg::NUM_W-1:0] sub;
    logic [bfs_pkg::DEN_W-1:0] din;
    logic [bfs_pkg::QUO_W-1:0] qin;
    logic [bfs_pkg::QUO_W-1:0] qnext;
    logic                      ge;

    if (k == 0) begin : g_first
      assign rin = num_i;
      assign din = den_i;
      assign qin = '0;
    end else begin : g_next
      assign rin = rem_q[k-1];
      assign din = den_q[k-1];
      assign qin = quo_q[k-1];
    end

    always_comb begin
      sub      = bfs_pkg::NUM_W'(din) << B;
      ge       = rin >= sub;
      qnext    = qin;
      qnext[B] = ge;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? rin - sub : rin;
        den_q[k] <= din;
        quo_q[k] <= qnext;
      end
    end
  end

  assign quo_o = quo_q[bfs_pkg::QUO_W-1];

endmodule
`default_nettype wire

// ----- hdl/bfs_mem.sv -----
`default_nettype none
module bfs_mem (
  input  wire logic                         clk_i,
  input  wire logic                         en_i,
  input  wire logic                         we_i,
  input  wire logic [bfs_pkg::ADDR_W-1:0]   waddr_i,
  input  wire logic [bfs_pkg::COLOR_W-1:0]  wdata_i,
  input  wire logic [bfs_pkg::ADDR_W-1:0]   raddr0_i,
  input  wire logic [bfs_pkg::ADDR_W-1:0]   raddr1_i,
  output logic      [bfs_pkg::COLOR_W-1:0]  rdata0_o,
  output logic      [bfs_pkg::COLOR_W-1:0]  rdata1_o
);

  logic [bfs_pkg::COLOR_W-1:0] mem_q [bfs_pkg::DEPTH];
  logic [bfs_pkg::COLOR_W-1:0] rd0_q;
  logic [bfs_pkg::COLOR_W-1:0] rd1_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rd0_q <= mem_q[raddr0_i];
      rd1_q <= mem_q[raddr1_i];
    end
  end

  assign rdata0_o = rd0_q;
  assign rdata1_o = rd1_q;

endmodule
`default_nettype wire

// ----- hdl/bilinear_frame_scaler_unit.sv -----
// Throughput: one item per cycle; the 17-stage long dividers and the frame reads are
// fully pipelined, and the whole pipeline holds while the output stalls.
// Writes travel the same pipeline and update the frame at the read stage; they give no result.
// Reset (rst_ni low, asynchronous): configuration back to defaults, all stages empty;
// the frame store keeps whatever it held and is not cleared.
`default_nettype none
module bilinear_frame_scaler_unit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  bfs_in_if.sink                               in_ch,
  bfs_out_if.source                            out_ch,
  input  wire logic                            cfg_we_i,
  input  wire logic [bfs_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [bfs_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int QW = bfs_pkg::QUO_W;

  // configuration
  logic [8:0] src_w_q, src_h_q, dst_w_q, dst_l_q;
  logic [7:0] dst_h_q, dst_t_q;
  logic       filt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= 9'd160;
      src_h_q <= 9'd144;
      dst_w_q <= 9'd160;
      dst_h_q <= 8'd144;
      dst_l_q <= 9'd0;
      dst_t_q <= 8'd0;
      filt_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bfs_pkg::CFG_SRC_W:  src_w_q <= cfg_data_i;
        bfs_pkg::CFG_SRC_H:  src_h_q <= cfg_data_i;
        bfs_pkg::CFG_DST_W:  dst_w_q <= cfg_data_i;
        bfs_pkg::CFG_DST_H:  dst_h_q <= cfg_data_i[7:0];
        bfs_pkg::CFG_DST_L:  dst_l_q <= cfg_data_i;
        bfs_pkg::CFG_DST_T:  dst_t_q <= cfg_data_i[7:0];
        bfs_pkg::CFG_FILTER: filt_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // whole pipeline advances unless the output register holds an untaken result
  logic out_vld_q;
  logic en;
  assign en          = !out_vld_q || out_ch.ready;
  assign in_ch.ready = en;

  // stage A: checks, offset, division operands
  bfs_pkg::side_t          side_a_d;
  logic [18:0]             prod_x;
  logic [17:0]             prod_y;
  logic [9:0]              mul_x;
  logic [8:0]              mul_y;
  logic [9:0]              col;
  logic [18:0]             row;
  logic [bfs_pkg::NUM_W-1:0] num_x_d, num_y_d, num_x_q, num_y_q;
  logic [bfs_pkg::DEN_W-1:0] den_x_d, den_y_d, den_x_q, den_y_q;
  logic                    sizes_ok;
  logic                    pos_ok;

  always_comb begin
    mul_x   = filt_q ? {in_ch.pos_x, 1'b1} : {1'b0, in_ch.pos_x};
    mul_y   = filt_q ? {in_ch.pos_y, 1'b1} : {1'b0, in_ch.pos_y};
    prod_x  = 19'(mul_x) * 19'(src_w_q);
    prod_y  = 18'(mul_y) * 18'(src_h_q);
    num_x_d = filt_q ? {prod_x, 8'h00} : bfs_pkg::NUM_W'(prod_x);
    num_y_d = filt_q ? bfs_pkg::NUM_W'({prod_y, 8'h00}) : bfs_pkg::NUM_W'(prod_y);
    den_x_d = filt_q ? {dst_w_q, 1'b0} : {1'b0, dst_w_q};
    den_y_d = filt_q ? {1'b0, dst_h_q, 1'b0} : {2'b00, dst_h_q};

    sizes_ok = src_w_q != '0 && src_h_q != '0 &&
               src_w_q <= 9'(bfs_pkg::SRC_MAX_W) && 10'(src_h_q) <= 10'(bfs_pkg::SRC_MAX_H) &&
               dst_w_q != '0 && dst_h_q != '0 &&
               dst_w_q <= 9'(bfs_pkg::SCREEN_W) && dst_h_q <= 8'(bfs_pkg::SCREEN_H);
    col    = 10'(dst_l_q) + 10'(in_ch.pos_x);
    pos_ok = in_ch.pos_x < dst_w_q && in_ch.pos_y < dst_h_q &&
             col < 10'(bfs_pkg::SCREEN_W) &&
             9'(dst_t_q) + 9'(in_ch.pos_y) < 9'(bfs_pkg::SCREEN_H);
    row    = 19'(bfs_pkg::SCREEN_H - 1) - 19'(dst_t_q) - 19'(in_ch.pos_y);

    side_a_d.vld   = in_ch.valid;
    side_a_d.cmd   = in_ch.cmd;
    side_a_d.x     = in_ch.pos_x;
    side_a_d.y     = in_ch.pos_y;
    side_a_d.color = in_ch.pixel_color;
    side_a_d.ok    = sizes_ok && pos_ok;
    side_a_d.off   = side_a_d.ok ?
                     (19'(col) * 19'(bfs_pkg::SCREEN_H) + row) * 19'(3) : '0;
  end

  // side data alongside the dividers; entry 0 is stage A
  bfs_pkg::side_t side_q [QW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= QW; k++) begin
        side_q[k] <= '0;
      end
    end else if (en) begin
      side_q[0] <= side_a_d;
      for (int k = 1; k <= QW; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      num_x_q <= num_x_d;
      num_y_q <= num_y_d;
      den_x_q <= den_x_d;
      den_y_q <= den_y_d;
    end
  end

  logic [QW-1:0] quo_x, quo_y;

  bfs_div u_div_x (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (num_x_q),
    .den_i (den_x_q),
    .quo_o (quo_x)
  );

  bfs_div u_div_y (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (num_y_q),
    .den_i (den_y_q),
    .quo_o (quo_y)
  );

  // map stage: nearest index, or in filter mode half-pixel offset, clamp, neighbor indices and weight
  function automatic logic [23:0] map_axis(input logic [QW-1:0] q, input logic [8:0] s,
                                           input logic f);
    logic [QW-1:0] p;
    logic [QW-1:0] pmax;
    logic [7:0]    i0;
    logic [7:0]    i1;
    logic [7:0]    w;
    logic [8:0]    nx;
    if (!f) begin
      i0 = q[7:0];
      i1 = i0;
      w  = '0;
    end else begin
      p    = (q < QW'(bfs_pkg::HALF_PIX)) ? '0 : q - QW'(bfs_pkg::HALF_PIX);
      pmax = QW'({s - 9'd1, 8'h00});
      if (p > pmax) begin
        p = pmax;
      end
      i0 = p[15:8];
      w  = p[7:0];
      nx = 9'(i0) + 9'd1;
      i1 = (nx < s) ? nx[7:0] : i0;
    end
    return {i0, i1, w};
  endfunction

  logic [23:0]    map_x_q, map_y_q;
  bfs_pkg::side_t side_m_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_m_q <= '0;
    end else if (en) begin
      side_m_q <= side_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      map_x_q <= map_axis(quo_x, src_w_q, filt_q);
      map_y_q <= map_axis(quo_y, src_h_q, filt_q);
    end
  end

  // read stage: two copies of the frame give four reads a cycle while the pipeline advances
  logic [bfs_pkg::COLOR_W-1:0] tl, tr, bl, br;
  logic                        mem_we;
  logic [bfs_pkg::ADDR_W-1:0]  mem_waddr;

  // write only while passing into the read stage, keeping program order
  assign mem_we    = en && side_m_q.vld && side_m_q.cmd == bfs_pkg::CMD_WRITE &&
                     !side_m_q.x[8];
  assign mem_waddr = {side_m_q.y, side_m_q.x[7:0]};

  bfs_mem u_mem_top (
    .clk_i    (clk_i),
    .en_i     (en),
    .we_i     (mem_we),
    .waddr_i  (mem_waddr),
    .wdata_i  (side_m_q.color),
    .raddr0_i ({map_y_q[23:16], map_x_q[23:16]}),
    .raddr1_i ({map_y_q[23:16], map_x_q[15:8]}),
    .rdata0_o (tl),
    .rdata1_o (tr)
  );

  bfs_mem u_mem_bot (
    .clk_i    (clk_i),
    .en_i     (en),
    .we_i     (mem_we),
    .waddr_i  (mem_waddr),
    .wdata_i  (side_m_q.color),
    .raddr0_i ({map_y_q[15:8], map_x_q[23:16]}),
    .raddr1_i ({map_y_q[15:8], map_x_q[15:8]}),
    .rdata0_o (bl),
    .rdata1_o (br)
  );

  bfs_pkg::side_t side_r_q;
  logic [7:0]     wx_r_q, wy_r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_r_q <= '0;
    end else if (en) begin
      side_r_q <= side_m_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      wx_r_q <= map_x_q[7:0];
      wy_r_q <= map_y_q[7:0];
    end
  end

  // horizontal blend
  logic [16:0]    up_d [bfs_pkg::NUM_CH];
  logic [16:0]    lo_d [bfs_pkg::NUM_CH];
  logic [16:0]    up_q [bfs_pkg::NUM_CH];
  logic [16:0]    lo_q [bfs_pkg::NUM_CH];
  logic [8:0]     wx_inv;
  bfs_pkg::side_t side_b_q;
  logic [7:0]     wy_b_q;

  always_comb begin
    wx_inv = 9'(bfs_pkg::ONE_W) - 9'(wx_r_q);
    for (int c = 0; c < bfs_pkg::NUM_CH; c++) begin
      up_d[c] = 17'(tl[c*bfs_pkg::CHAN_W +: bfs_pkg::CHAN_W]) * 17'(wx_inv) +
                17'(tr[c*bfs_pkg::CHAN_W +: bfs_pkg::CHAN_W]) * 17'(wx_r_q);
      lo_d[c] = 17'(bl[c*bfs_pkg::CHAN_W +: bfs_pkg::CHAN_W]) * 17'(wx_inv) +
                17'(br[c*bfs_pkg::CHAN_W +: bfs_pkg::CHAN_W]) * 17'(wx_r_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_b_q <= '0;
    end else if (en) begin
      side_b_q <= side_r_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      up_q   <= up_d;
      lo_q   <= lo_d;
      wy_b_q <= wy_r_q;
    end
  end

  // vertical blend with rounding into the output register
  logic [8:0]                  wy_inv;
  logic [24:0]                 vsum;
  logic [bfs_pkg::COLOR_W-1:0] color_d;

  always_comb begin
    wy_inv  = 9'(bfs_pkg::ONE_W) - 9'(wy_b_q);
    color_d = '0;
    vsum    = '0;
    for (int c = 0; c < bfs_pkg::NUM_CH; c++) begin
      vsum = 25'(up_q[c]) * 25'(wy_inv) + 25'(lo_q[c]) * 25'(wy_b_q) +
             25'(bfs_pkg::ROUND_OFS);
      color_d[c*bfs_pkg::CHAN_W +: bfs_pkg::CHAN_W] = vsum[23:16];
    end
  end

  logic [bfs_pkg::COLOR_W-1:0] out_color_q;
  logic [bfs_pkg::OFF_W-1:0]   out_off_q;
  logic                        out_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= side_b_q.vld && side_b_q.cmd == bfs_pkg::CMD_REQUEST;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_color_q <= side_b_q.ok ? color_d : '0;
      out_off_q   <= side_b_q.off;
      out_ok_q    <= side_b_q.ok;
    end
  end

  assign out_ch.valid       = out_vld_q;
  assign out_ch.out_color   = out_color_q;
  assign out_ch.byte_offset = out_off_q;
  assign out_ch.valid_res   = out_ok_q;

`ifndef ASSERT_OFF
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && !out_ch.valid_res |-> out_ch.out_color == '0 && out_ch.byte_offset == '0)
    else $error("invalid result carries nonzero fields");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while output stalled");

  a_request_reaches_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && side_b_q.vld && side_b_q.cmd == bfs_pkg::CMD_REQUEST |=> out_ch.valid)
    else $error("request lost before output register");

  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && side_b_q.vld && side_b_q.cmd == bfs_pkg::CMD_WRITE |=> !out_ch.valid)
    else $error("write produced a result");
`endif

endmodule
`default_nettype wire
